FILE: design/slpg_pkg.sv
// Shared constants, register codes and config type for the status LED pattern generator.
`timescale 1ns / 1ps
`default_nettype none
package slpg_pkg;

    localparam int DEF_TIMER_WIDTH = 32;
    localparam int TICKS_W         = 16;
    localparam int TIME_W          = 24;
    localparam int BURST_W         = 5;
    localparam int MODE_W          = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STILL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLASH = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BURST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd6;

    localparam logic [BURST_W-1:0] BURST_MIN = 5'd1;
    localparam logic [BURST_W-1:0] BURST_MAX = 5'd20;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               still_level;
        logic [TIME_W-1:0]  on_ticks;
        logic [TIME_W-1:0]  off_ticks;
        logic [TIME_W-1:0]  pause_ticks;
        logic [BURST_W-1:0] burst;
        logic               invert;
    } t_cfg;

    function automatic logic [BURST_W-1:0] clamp_burst(input logic [BURST_W-1:0] b);
        logic [BURST_W-1:0] r;
        r = b;
        if (b < BURST_MIN) begin
            r = BURST_MIN;
        end else if (b > BURST_MAX) begin
            r = BURST_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/slpg_if.sv
// Handshake interfaces for the tick input, the LED result and the config write channel.
`timescale 1ns / 1ps
`default_nettype none
interface slpg_in_if;
    logic                        valid;
    logic                        ready;
    logic [slpg_pkg::TICKS_W-1:0] elapsed_ticks;

    modport source (output valid, output elapsed_ticks, input ready);
    modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface slpg_out_if;
    logic valid;
    logic ready;
    logic led_level;
    logic level_changed;

    modport source (output valid, output led_level, output level_changed, input ready);
    modport sink   (input valid, input led_level, input level_changed, output ready);
endinterface

interface slpg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [slpg_pkg::CFG_IDX_W-1:0]  index;
    logic [slpg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/slpg_step.sv
// Next-state logic of the pattern: saturating tick add and the per-mode update.
`timescale 1ns / 1ps
`default_nettype none
module slpg_step #(
    parameter int TIMER_WIDTH = slpg_pkg::DEF_TIMER_WIDTH
) (
    input  slpg_pkg::t_cfg                    i_cfg,
    input  logic [TIMER_WIDTH-1:0]            i_tick,
    input  logic [slpg_pkg::BURST_W-1:0]      i_remaining,
    input  logic                              i_led,
    input  logic [slpg_pkg::TICKS_W-1:0]      i_ticks,
    output logic [TIMER_WIDTH-1:0]            o_tick,
    output logic [slpg_pkg::BURST_W-1:0]      o_remaining,
    output logic                              o_led
);
    // compare width covers both the timer and the on+off sum
    localparam int CW = (TIMER_WIDTH > slpg_pkg::TIME_W + 1) ? TIMER_WIDTH
                                                              : slpg_pkg::TIME_W + 1;
    localparam logic [slpg_pkg::BURST_W-1:0] ONE_BLINK =
        {{(slpg_pkg::BURST_W-1){1'b0}}, 1'b1};

    logic [TIMER_WIDTH:0]           sum;
    logic [TIMER_WIDTH-1:0]         tick_sat;
    logic [CW-1:0]                  tick_x;
    logic [CW-1:0]                  period;
    logic [CW-1:0]                  on_x;
    logic [CW-1:0]                  pause_x;
    logic                           past_period;
    logic                           before_on;
    logic                           past_pause;
    logic                           on_nonzero;
    logic                           reload;
    logic                           waiting;
    logic                           period_hit;
    logic                           on_hit;
    logic [slpg_pkg::BURST_W-1:0]   rem_eff;

    assign sum      = {1'b0, i_tick} + (TIMER_WIDTH + 1)'(i_ticks);
    assign tick_sat = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];

    assign tick_x  = CW'(tick_sat);
    assign period  = CW'(i_cfg.on_ticks) + CW'(i_cfg.off_ticks);
    assign on_x    = CW'(i_cfg.on_ticks);
    assign pause_x = CW'(i_cfg.pause_ticks);

    assign past_period = tick_x >= period;
    assign before_on   = tick_x < on_x;
    assign past_pause  = tick_x >= pause_x;
    assign on_nonzero  = (i_cfg.on_ticks != '0);

    // end of pause: the counter restarts from zero, so compare zero instead
    assign reload     = (i_remaining == '0) && past_pause;
    assign waiting    = (i_remaining == '0) && !past_pause;
    assign period_hit = reload ? (period == '0) : past_period;
    assign on_hit     = reload ? on_nonzero : before_on;
    assign rem_eff    = reload ? i_cfg.burst : i_remaining;

    always_comb begin
        o_tick      = tick_sat;
        o_remaining = i_remaining;
        o_led       = i_led;
        case (i_cfg.mode)
            slpg_pkg::MODE_STILL: begin
                o_led = i_cfg.still_level;
            end
            slpg_pkg::MODE_BLINK: begin
                if (past_period) begin
                    o_tick = '0;
                    o_led  = on_nonzero;
                end else begin
                    o_led = before_on;
                end
            end
            slpg_pkg::MODE_COUNT: begin
                if (!waiting) begin
                    if (period_hit) begin
                        // end of a blink period: hold the level, count it down
                        o_tick      = '0;
                        o_remaining = (rem_eff != '0) ? rem_eff - ONE_BLINK : rem_eff;
                    end else begin
                        if (reload) begin
                            o_tick = '0;
                        end
                        o_remaining = rem_eff;
                        o_led       = on_hit;
                    end
                end
            end
            slpg_pkg::MODE_FLASH: begin
                o_led = before_on;
            end
            default: begin
                // stop and unused codes hold the level
                o_led = i_led;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/status_led_pattern_generator.sv
// Top level of the status LED pattern generator: config registers, input and result stages.
//
// Each input transfer carries the ticks elapsed since the previous one; the block adds
// them to a saturating TIMER_WIDTH-bit counter, advances the selected pattern (stop,
// still, blink, count, flash) and returns one result: the pin level after optional
// inversion and a flag that marks a change of the internal LED state. An item passes
// through the input register and then the result register, and a new item is taken
// every cycle unless the result register is full and stalled by its sink; the pattern
// state updates in one pass of a TIMER_WIDTH-bit add followed by compares against
// on, on+off and pause. Writing any of the seven config registers restarts the
// pattern (counter cleared, LED off, blink count reloaded); the config channel is
// always ready and is meant to be used only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module status_led_pattern_generator #(
    parameter int TIMER_WIDTH = slpg_pkg::DEF_TIMER_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    slpg_in_if.sink      i_in,
    slpg_out_if.source   o_out,
    slpg_cfg_if.sink     i_cfg
);
    slpg_pkg::t_cfg                 r_cfg;
    slpg_pkg::t_cfg                 n_cfg;
    logic [TIMER_WIDTH-1:0]         r_tick;
    logic [TIMER_WIDTH-1:0]         n_tick;
    logic [slpg_pkg::BURST_W-1:0]   r_remaining;
    logic [slpg_pkg::BURST_W-1:0]   n_remaining;
    logic                           r_led;
    logic                           n_led;
    logic                           r_in_valid;
    logic [slpg_pkg::TICKS_W-1:0]   r_in_ticks;
    logic                           r_out_valid;
    logic                           r_out_level;
    logic                           r_out_changed;

    logic [TIMER_WIDTH-1:0]         step_tick;
    logic [slpg_pkg::BURST_W-1:0]   step_remaining;
    logic                           step_led;
    logic                           cfg_write;
    logic                           cfg_known;
    logic                           advance;
    logic                           compute;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;

    assign advance    = !r_out_valid || o_out.ready;
    assign compute    = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    slpg_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_tick      (r_tick),
        .i_remaining (r_remaining),
        .i_led       (r_led),
        .i_ticks     (r_in_ticks),
        .o_tick      (step_tick),
        .o_remaining (step_remaining),
        .o_led       (step_led)
    );

    always_comb begin
        n_cfg     = r_cfg;
        cfg_known = 1'b1;
        case (i_cfg.index)
            slpg_pkg::REG_MODE:   n_cfg.mode        = i_cfg.data[slpg_pkg::MODE_W-1:0];
            slpg_pkg::REG_STILL:  n_cfg.still_level = i_cfg.data[0];
            slpg_pkg::REG_ON:     n_cfg.on_ticks    = i_cfg.data[slpg_pkg::TIME_W-1:0];
            slpg_pkg::REG_OFF:    n_cfg.off_ticks   = i_cfg.data[slpg_pkg::TIME_W-1:0];
            slpg_pkg::REG_PAUSE:  n_cfg.pause_ticks = i_cfg.data[slpg_pkg::TIME_W-1:0];
            slpg_pkg::REG_BURST:  n_cfg.burst       =
                slpg_pkg::clamp_burst(i_cfg.data[slpg_pkg::BURST_W-1:0]);
            slpg_pkg::REG_INVERT: n_cfg.invert      = i_cfg.data[0];
            default:              cfg_known         = 1'b0;
        endcase
    end

    always_comb begin
        n_tick      = r_tick;
        n_remaining = r_remaining;
        n_led       = r_led;
        if (cfg_write && cfg_known) begin
            // restart the pattern
            n_tick      = '0;
            n_remaining = n_cfg.burst;
            n_led       = 1'b0;
        end else if (compute) begin
            n_tick      = step_tick;
            n_remaining = step_remaining;
            n_led       = step_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '{mode: slpg_pkg::MODE_STOP, still_level: 1'b0, on_ticks: '0,
                             off_ticks: '0, pause_ticks: '0, burst: slpg_pkg::BURST_MIN,
                             invert: 1'b0};
            r_tick      <= '0;
            r_remaining <= slpg_pkg::BURST_MIN;
            r_led       <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write && cfg_known) begin
                r_cfg <= n_cfg;
            end
            r_tick      <= n_tick;
            r_remaining <= n_remaining;
            r_led       <= n_led;
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_ticks <= i_in.elapsed_ticks;
        end
        if (compute) begin
            r_out_level   <= step_led ^ r_cfg.invert;
            r_out_changed <= step_led != r_led;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.led_level     = r_out_level;
    assign o_out.level_changed = r_out_changed;

endmodule
`default_nettype wire

FILE: design/slpg_checker.sv
// Port-level assertions for the status LED pattern generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module slpg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_level,
    input wire logic i_out_changed,
    input wire logic i_cfg_ready
);
    // nothing comes out of reset pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // an empty result register never blocks the input side
    a_skid_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // an item transferred while the sink is ready moves through the input register into the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid)
        else $error("result missing two cycles after transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_level) && $stable(i_out_changed))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_level   (o_out.led_level),
    .i_out_changed (o_out.level_changed),
    .i_cfg_ready   (i_cfg.ready)
);
`default_nettype wire
